[rtl/erma_pkg.sv]
// Package for the event rate moving average block: sizes, event codes,
// state encoding and the structs shared by the top level and the divider.
// No dependencies.
package erma_pkg;

   localparam int NUM_SOURCES = 256;
   localparam int WINDOW      = 64;

   localparam int SRC_W    = 8;
   localparam int TYPE_W   = 5;
   localparam int SEC_W    = 32;
   localparam int USEC_W   = 20;
   localparam int RATE_W   = 10;
   localparam int TIME_W   = 42;
   localparam int MS_PER_S = 1000;

   localparam int SRC_AW    = $clog2(NUM_SOURCES);
   localparam int SLOT_W    = $clog2(WINDOW);
   localparam int CNT_W     = $clog2(WINDOW + 1);
   localparam int SUM_W     = RATE_W + SLOT_W;
   localparam int HIST_AW   = SRC_AW + SLOT_W;
   localparam int HIST_DEPTH = 1 << HIST_AW;

   localparam int DIVD_W = (SUM_W > USEC_W) ? SUM_W : USEC_W;
   localparam int DIVS_W = (CNT_W > RATE_W) ? CNT_W : RATE_W;
   localparam int STEP_W = $clog2(DIVD_W + 1);

   localparam logic [TYPE_W-1:0] EV_REL = TYPE_W'(2);
   localparam logic [TYPE_W-1:0] EV_ABS = TYPE_W'(3);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_USDIV,
      ST_NOW,
      ST_GAP,
      ST_RDIV,
      ST_UPD,
      ST_ADIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0] last_ms;
      logic [CNT_W-1:0]  count;
      logic [SLOT_W-1:0] slot;
      logic [SUM_W-1:0]  sum;
   } row_type;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

[rtl/erma_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// The dividend arrives left-aligned; after N steps the word holds the quotient.
// Depends on erma_pkg.
module erma_div (
   input  logic                          clock,
   input  logic                          reset,
   input  erma_pkg::div_ctl_type         ctl,
   input  logic [erma_pkg::DIVD_W-1:0]   dividend,
   input  logic [erma_pkg::DIVS_W-1:0]   divisor,
   output erma_pkg::div_stat_type        stat,
   output logic [erma_pkg::DIVD_W-1:0]   quotient
);

   logic                          busy_ff, busy_in;
   logic [erma_pkg::STEP_W-1:0]   cnt_ff, cnt_in;
   logic [erma_pkg::DIVD_W-1:0]   dq_ff, dq_in;
   logic [erma_pkg::DIVS_W-1:0]   rem_ff, rem_in;
   logic [erma_pkg::DIVS_W-1:0]   dvs_ff, dvs_in;
   logic [erma_pkg::DIVS_W:0]     trial;
   logic [erma_pkg::DIVS_W:0]     trial_sub;
   logic                          fits;

   assign trial     = {rem_ff, dq_ff[erma_pkg::DIVD_W-1]};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign fits      = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = ctl.steps;
         dq_in   = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         busy_in = (cnt_ff != erma_pkg::STEP_W'(1));
         dq_in  = {dq_ff[erma_pkg::DIVD_W-2:0], fits};
         rem_in = fits ? trial_sub[erma_pkg::DIVS_W-1:0] : trial[erma_pkg::DIVS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = busy_ff && (cnt_ff == erma_pkg::STEP_W'(1));
   assign quotient  = dq_ff;

endmodule

[rtl/event_rate_moving_average.sv]
// Event rate meter with a per-source moving average over the last WINDOW rates.
// Top level; depends on erma_pkg and erma_div.
//
// Usage:
//   Input channel req_*: one timestamped event per transaction. Only relative
//   and absolute motion events are measured; others are taken and dropped.
//   Result channel rsp_*: source, latest rate in Hz and floor mean of the
//   filled window, one transaction per event with a nonzero rate.
//   A measured event is worked on from acceptance until its result is loaded
//   into the output register: the shared bit-serial divider runs 20 steps for the
//   millisecond conversion, 10 for the rate and 16 for the average, with
//   sequencing states between them. Only then can the next event be taken.
//   A dropped event leaves the block idle; an event with zero rate ends after the gap check.
//   req_stall is high while an event is in work.
//   The result sits in an output register; while the receiver stalls, the
//   block still takes and works on the next event and waits at its end.
//   Reset clears the per-source valid bits, so all timestamps, counts, slots
//   and sums read as zero; no clearing pass is needed. The rate history
//   memory is not cleared.
module event_rate_moving_average (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [erma_pkg::SRC_W-1:0]    req_source,
   input  logic [erma_pkg::TYPE_W-1:0]   req_event_type,
   input  logic [erma_pkg::SEC_W-1:0]    req_seconds,
   input  logic [erma_pkg::USEC_W-1:0]   req_microseconds,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [erma_pkg::SRC_W-1:0]    rsp_out_source,
   output logic [erma_pkg::RATE_W-1:0]   rsp_latest_rate,
   output logic [erma_pkg::RATE_W-1:0]   rsp_average_rate
);

   erma_pkg::state_type             state_ff, state_in;
   logic                            msfix_ff, msfix_in;
   logic [erma_pkg::NUM_SOURCES-1:0] vld_ff, vld_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   logic [erma_pkg::SRC_W-1:0]      src_ff, src_in;
   logic [erma_pkg::SEC_W-1:0]      sec_ff, sec_in;
   logic [erma_pkg::TIME_W-1:0]     ms_ff, ms_in;
   logic [erma_pkg::TIME_W-1:0]     now_ff, now_in;
   logic [erma_pkg::RATE_W-1:0]     rate_ff, rate_in;
   logic [erma_pkg::SRC_W-1:0]      rsp_src_ff, rsp_src_in;
   logic [erma_pkg::RATE_W-1:0]     rsp_rate_ff, rsp_rate_in;
   logic [erma_pkg::RATE_W-1:0]     rsp_avg_ff, rsp_avg_in;

   erma_pkg::row_type               row_mem [erma_pkg::NUM_SOURCES];
   erma_pkg::row_type               row_rd_ff;
   logic                            vld_rd_ff;
   logic [erma_pkg::RATE_W-1:0]     hist_mem [erma_pkg::HIST_DEPTH];
   logic [erma_pkg::RATE_W-1:0]     hist_rd_ff;

   erma_pkg::div_ctl_type           div_ctl;
   erma_pkg::div_stat_type          div_stat;
   logic [erma_pkg::DIVD_W-1:0]     div_dividend;
   logic [erma_pkg::DIVS_W-1:0]     div_divisor;
   logic [erma_pkg::DIVD_W-1:0]     div_quot;

   logic                            req_accept;
   logic                            counted;
   logic [erma_pkg::SRC_AW-1:0]     req_addr;
   logic [erma_pkg::SRC_AW-1:0]     src_addr;
   erma_pkg::row_type               cur_row;
   erma_pkg::row_type               row_wdata;
   logic                            row_we;
   logic                            hist_re;
   logic                            hist_we;
   logic [erma_pkg::HIST_AW-1:0]    hist_addr;
   logic [erma_pkg::TIME_W-1:0]     ms_start;
   logic [erma_pkg::TIME_W-1:0]     ms_fix;
   logic [erma_pkg::TIME_W:0]       diff;
   logic                            gap_ok;
   logic                            full;
   logic [erma_pkg::RATE_W-1:0]     old_rate;
   logic [erma_pkg::SUM_W-1:0]      sum_new;
   logic [erma_pkg::CNT_W-1:0]      cnt_new;
   logic [erma_pkg::SLOT_W-1:0]     slot_new;
   logic                            rsp_load;

   assign req_accept = req_valid && !req_stall;
   assign counted    = ((req_event_type == erma_pkg::EV_REL) ||
                        (req_event_type == erma_pkg::EV_ABS)) &&
                       (32'(req_source) < 32'(erma_pkg::NUM_SOURCES));
   assign req_addr   = erma_pkg::SRC_AW'(req_source);
   assign src_addr   = erma_pkg::SRC_AW'(src_ff);

   // seconds * 1000 = s*1024 - s*32 + s*8; ms_ff takes the first two terms, msfix_ff then adds s*8
   assign ms_start = (erma_pkg::TIME_W'(req_seconds) << 10) -
                     (erma_pkg::TIME_W'(req_seconds) << 5);
   assign ms_fix   = ms_ff + (erma_pkg::TIME_W'(sec_ff) << 3);

   assign cur_row = vld_rd_ff ? row_rd_ff : '0;
   assign diff    = {1'b0, now_ff} - {1'b0, cur_row.last_ms};
   assign gap_ok  = !diff[erma_pkg::TIME_W] &&
                    (diff[erma_pkg::TIME_W-1:0] != '0) &&
                    (diff[erma_pkg::TIME_W-1:0] <= erma_pkg::TIME_W'(erma_pkg::MS_PER_S));

   assign full     = cur_row.count >= erma_pkg::CNT_W'(erma_pkg::WINDOW);
   assign old_rate = full ? hist_rd_ff : '0;
   assign sum_new  = cur_row.sum - erma_pkg::SUM_W'(old_rate) +
                     erma_pkg::SUM_W'(div_quot[erma_pkg::RATE_W-1:0]);
   assign cnt_new  = full ? cur_row.count : cur_row.count + 1'b1;
   assign slot_new = (cur_row.slot == erma_pkg::SLOT_W'(erma_pkg::WINDOW - 1)) ?
                     '0 : cur_row.slot + 1'b1;
   assign hist_addr = {src_addr, cur_row.slot};

   erma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         erma_pkg::ST_IDLE: begin
            if (req_accept && counted) state_in = erma_pkg::ST_USDIV;
         end
         erma_pkg::ST_USDIV: begin
            if (div_stat.done) state_in = erma_pkg::ST_NOW;
         end
         erma_pkg::ST_NOW: begin
            state_in = erma_pkg::ST_GAP;
         end
         erma_pkg::ST_GAP: begin
            state_in = gap_ok ? erma_pkg::ST_RDIV : erma_pkg::ST_IDLE;
         end
         erma_pkg::ST_RDIV: begin
            if (div_stat.done) state_in = erma_pkg::ST_UPD;
         end
         erma_pkg::ST_UPD: begin
            state_in = erma_pkg::ST_ADIV;
         end
         erma_pkg::ST_ADIV: begin
            if (div_stat.done) state_in = erma_pkg::ST_EMIT;
         end
         erma_pkg::ST_EMIT: begin
            if (rsp_load) state_in = erma_pkg::ST_IDLE;
         end
         default: begin
            state_in = erma_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_stall     = 1'b1;
      div_ctl.start = 1'b0;
      div_ctl.steps = erma_pkg::STEP_W'(erma_pkg::USEC_W);
      div_dividend  = erma_pkg::DIVD_W'(req_microseconds) <<
                      (erma_pkg::DIVD_W - erma_pkg::USEC_W);
      div_divisor   = erma_pkg::DIVS_W'(erma_pkg::MS_PER_S);
      row_we        = 1'b0;
      row_wdata     = cur_row;
      hist_re       = 1'b0;
      hist_we       = 1'b0;
      rsp_load      = 1'b0;
      case (state_ff)
         erma_pkg::ST_IDLE: begin
            req_stall     = 1'b0;
            div_ctl.start = req_accept && counted;
         end
         erma_pkg::ST_GAP: begin
            div_ctl.start     = gap_ok;
            div_ctl.steps     = erma_pkg::STEP_W'(erma_pkg::RATE_W);
            div_dividend      = erma_pkg::DIVD_W'(erma_pkg::MS_PER_S) <<
                                (erma_pkg::DIVD_W - erma_pkg::RATE_W);
            div_divisor       = diff[erma_pkg::DIVS_W-1:0];
            row_we            = 1'b1;
            row_wdata.last_ms = now_ff;
            hist_re           = 1'b1;
         end
         erma_pkg::ST_UPD: begin
            div_ctl.start     = 1'b1;
            div_ctl.steps     = erma_pkg::STEP_W'(erma_pkg::SUM_W);
            div_dividend      = erma_pkg::DIVD_W'(sum_new) <<
                                (erma_pkg::DIVD_W - erma_pkg::SUM_W);
            div_divisor       = erma_pkg::DIVS_W'(cnt_new);
            row_we            = 1'b1;
            row_wdata.last_ms = now_ff;
            row_wdata.count   = cnt_new;
            row_wdata.slot    = slot_new;
            row_wdata.sum     = sum_new;
            hist_we           = 1'b1;
         end
         erma_pkg::ST_EMIT: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // datapath and control next values
   always_comb begin
      msfix_in     = (state_ff == erma_pkg::ST_IDLE) && req_accept && counted;
      vld_in       = vld_ff;
      src_in       = src_ff;
      sec_in       = sec_ff;
      ms_in        = ms_ff;
      now_in       = now_ff;
      rate_in      = rate_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_src_in   = rsp_src_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_avg_in   = rsp_avg_ff;
      if (req_accept) begin
         src_in = req_source;
         sec_in = req_seconds;
         ms_in  = ms_start;
      end else if (msfix_ff) begin
         ms_in = ms_fix;
      end
      if (state_ff == erma_pkg::ST_NOW) begin
         now_in = ms_ff + erma_pkg::TIME_W'(div_quot);
      end
      if (state_ff == erma_pkg::ST_GAP) begin
         vld_in[src_addr] = 1'b1;
      end
      if (state_ff == erma_pkg::ST_UPD) begin
         rate_in = div_quot[erma_pkg::RATE_W-1:0];
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_src_in   = src_ff;
         rsp_rate_in  = rate_ff;
         rsp_avg_in   = div_quot[erma_pkg::RATE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= erma_pkg::ST_IDLE;
         msfix_ff     <= 1'b0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         msfix_ff     <= msfix_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      sec_ff      <= sec_in;
      ms_ff       <= ms_in;
      now_ff      <= now_in;
      rate_ff     <= rate_in;
      rsp_src_ff  <= rsp_src_in;
      rsp_rate_ff <= rsp_rate_in;
      rsp_avg_ff  <= rsp_avg_in;
   end

   // per-source state memory
   always_ff @(posedge clock) begin
      if (req_accept) begin
         row_rd_ff <= row_mem[req_addr];
         vld_rd_ff <= vld_ff[req_addr];
      end
      if (row_we) begin
         row_mem[src_addr] <= row_wdata;
      end
   end

   // rate history memory
   always_ff @(posedge clock) begin
      if (hist_re) begin
         hist_rd_ff <= hist_mem[hist_addr];
      end
      if (hist_we) begin
         hist_mem[hist_addr] <= rate_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_source   = rsp_src_ff;
   assign rsp_latest_rate  = rsp_rate_ff;
   assign rsp_average_rate = rsp_avg_ff;

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == erma_pkg::ST_USDIV ||
                         state_ff == erma_pkg::ST_RDIV ||
                         state_ff == erma_pkg::ST_ADIV))
      else $error("divider finished outside a wait state");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_latest_rate != '0) &&
                     (rsp_latest_rate <= erma_pkg::RATE_W'(erma_pkg::MS_PER_S)) &&
                     (rsp_average_rate != '0) &&
                     (rsp_average_rate <= erma_pkg::RATE_W'(erma_pkg::MS_PER_S))))
      else $error("result rate out of range");

endmodule

[tb/event_rate_checker.sv]
`timescale 1ns / 1ps
// Checker for the event rate moving average block: watches both channels,
// predicts each source's latest rate and window mean, compares results.
// Depends on erma_pkg.
module event_rate_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [erma_pkg::SRC_W-1:0]    req_source,
   input  logic [erma_pkg::TYPE_W-1:0]   req_event_type,
   input  logic [erma_pkg::SEC_W-1:0]    req_seconds,
   input  logic [erma_pkg::USEC_W-1:0]   req_microseconds,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [erma_pkg::SRC_W-1:0]    rsp_out_source,
   input  logic [erma_pkg::RATE_W-1:0]   rsp_latest_rate,
   input  logic [erma_pkg::RATE_W-1:0]   rsp_average_rate,
   output int                            mismatch_count,
   output int                            rates_pending
);

   typedef struct packed {
      logic [erma_pkg::SRC_W-1:0]  source;
      logic [erma_pkg::RATE_W-1:0] latest;
      logic [erma_pkg::RATE_W-1:0] average;
   } rate_result_type;

   logic [erma_pkg::TIME_W-1:0] last_ms    [erma_pkg::NUM_SOURCES];
   logic [erma_pkg::RATE_W-1:0] history    [erma_pkg::NUM_SOURCES][erma_pkg::WINDOW];
   logic [erma_pkg::CNT_W-1:0]  fill_count [erma_pkg::NUM_SOURCES];
   logic [erma_pkg::SLOT_W-1:0] next_slot  [erma_pkg::NUM_SOURCES];
   logic [erma_pkg::SUM_W-1:0]  rate_sum   [erma_pkg::NUM_SOURCES];
   rate_result_type             expected_rates [$];

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic void predict_rate(input logic [erma_pkg::SRC_W-1:0] src,
                                        input logic [erma_pkg::TYPE_W-1:0] kind,
                                        input logic [erma_pkg::SEC_W-1:0] sec,
                                        input logic [erma_pkg::USEC_W-1:0] usec);
      logic [63:0]                 now_full;
      logic [erma_pkg::TIME_W-1:0] now_ms;
      logic [erma_pkg::TIME_W-1:0] prev_ms;
      logic [erma_pkg::TIME_W-1:0] rate;
      logic [erma_pkg::SLOT_W-1:0] s;
      rate_result_type             r;
      if (kind != erma_pkg::EV_REL && kind != erma_pkg::EV_ABS) return;
      now_full = 64'(sec) * 64'(erma_pkg::MS_PER_S) + 64'(usec) / 64'(erma_pkg::MS_PER_S);
      now_ms = now_full[erma_pkg::TIME_W-1:0];
      prev_ms = last_ms[src];
      last_ms[src] = now_ms;
      if (now_ms <= prev_ms) return;
      rate = erma_pkg::TIME_W'(erma_pkg::MS_PER_S) / (now_ms - prev_ms);
      if (rate == '0) return;
      s = next_slot[src];
      if (fill_count[src] >= erma_pkg::WINDOW)
         rate_sum[src] = rate_sum[src] - erma_pkg::SUM_W'(history[src][s]);
      else
         fill_count[src] = fill_count[src] + 1'b1;
      history[src][s] = rate[erma_pkg::RATE_W-1:0];
      rate_sum[src] = rate_sum[src] + erma_pkg::SUM_W'(rate);
      next_slot[src] = erma_pkg::SLOT_W'((int'(s) + 1) % erma_pkg::WINDOW);
      r.source = src;
      r.latest = rate[erma_pkg::RATE_W-1:0];
      r.average = erma_pkg::RATE_W'(rate_sum[src] / fill_count[src]);
      expected_rates.push_back(r);
   endfunction

   task automatic check_result();
      rate_result_type want;
      if (expected_rates.size() == 0) begin
         report_mismatch($sformatf("unexpected result: source %0d rate %0d mean %0d",
                                   rsp_out_source, rsp_latest_rate, rsp_average_rate));
         return;
      end
      want = expected_rates.pop_front();
      if (rsp_out_source !== want.source)
         report_mismatch($sformatf("source: got %0d, want %0d",
                                   rsp_out_source, want.source));
      if (rsp_latest_rate !== want.latest)
         report_mismatch($sformatf("source %0d latest rate: got %0d, want %0d",
                                   want.source, rsp_latest_rate, want.latest));
      if (rsp_average_rate !== want.average)
         report_mismatch($sformatf("source %0d mean rate: got %0d, want %0d",
                                   want.source, rsp_average_rate, want.average));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < erma_pkg::NUM_SOURCES; i++) begin
            last_ms[i] = '0;
            fill_count[i] = '0;
            next_slot[i] = '0;
            rate_sum[i] = '0;
         end
         expected_rates.delete();
         mismatch_count = 0;
         rates_pending <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall)
            predict_rate(req_source, req_event_type, req_seconds, req_microseconds);
         rates_pending <= expected_rates.size();
      end
   end

endmodule

[tb/tb_event_rate_moving_average.sv]
`timescale 1ns / 1ps
// Top of the event rate moving average testbench: clock, reset, event
// stimulus and receiver stalls; the verdict comes from event_rate_checker.
// Depends on erma_pkg, event_rate_moving_average and event_rate_checker.
module tb_event_rate_moving_average;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [erma_pkg::SRC_W-1:0]    req_source = '0;
   logic [erma_pkg::TYPE_W-1:0]   req_event_type = '0;
   logic [erma_pkg::SEC_W-1:0]    req_seconds = '0;
   logic [erma_pkg::USEC_W-1:0]   req_microseconds = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [erma_pkg::SRC_W-1:0]    rsp_out_source;
   logic [erma_pkg::RATE_W-1:0]   rsp_latest_rate;
   logic [erma_pkg::RATE_W-1:0]   rsp_average_rate;

   int                            mismatch_count;
   int                            rates_pending;
   int                            idle_pct = 26;
   int                            stall_pct = 26;
   longint unsigned               sent_ms [erma_pkg::NUM_SOURCES];

   event_rate_moving_average dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_source       (req_source),
      .req_event_type   (req_event_type),
      .req_seconds      (req_seconds),
      .req_microseconds (req_microseconds),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_source   (rsp_out_source),
      .rsp_latest_rate  (rsp_latest_rate),
      .rsp_average_rate (rsp_average_rate)
   );

   event_rate_checker rate_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_source       (req_source),
      .req_event_type   (req_event_type),
      .req_seconds      (req_seconds),
      .req_microseconds (req_microseconds),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_source   (rsp_out_source),
      .rsp_latest_rate  (rsp_latest_rate),
      .rsp_average_rate (rsp_average_rate),
      .mismatch_count   (mismatch_count),
      .rates_pending    (rates_pending)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   task automatic send_event(input logic [erma_pkg::SRC_W-1:0] src,
                             input logic [erma_pkg::TYPE_W-1:0] kind,
                             input logic [erma_pkg::SEC_W-1:0] sec,
                             input logic [erma_pkg::USEC_W-1:0] usec);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_source <= src;
      req_event_type <= kind;
      req_seconds <= sec;
      req_microseconds <= usec;
      if (kind == erma_pkg::EV_REL || kind == erma_pkg::EV_ABS)
         sent_ms[src] = 64'(sec) * erma_pkg::MS_PER_S + 64'(usec) / erma_pkg::MS_PER_S;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // counted event at a given millisecond, random sub-millisecond part
   task automatic send_ms(input logic [erma_pkg::SRC_W-1:0] src, input longint unsigned ms);
      logic [erma_pkg::TYPE_W-1:0] kind;
      kind = $urandom_range(1) ? erma_pkg::EV_REL : erma_pkg::EV_ABS;
      send_event(src, kind, erma_pkg::SEC_W'(ms / erma_pkg::MS_PER_S),
                 erma_pkg::USEC_W'((ms % erma_pkg::MS_PER_S) * erma_pkg::MS_PER_S +
                                   $urandom_range(999)));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rates_pending != 0) @(posedge clock);
   endtask

   initial begin
      int                          pick;
      int                          gap;
      logic [erma_pkg::SRC_W-1:0]  src;
      logic [erma_pkg::TYPE_W-1:0] kind;
      longint unsigned             back;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // first event at time zero, then gaps of 1 and 2 ms
      send_event(8'd0, erma_pkg::EV_REL, 32'd0, 20'd0);
      send_event(8'd0, erma_pkg::EV_REL, 32'd0, 20'd1000);
      send_event(8'd0, erma_pkg::EV_ABS, 32'd0, 20'd3999);
      // equal time, then time running backwards
      send_event(8'd0, erma_pkg::EV_ABS, 32'd0, 20'd3500);
      send_event(8'd0, erma_pkg::EV_REL, 32'd0, 20'd1000);
      // gap of exactly 1000 ms, then 1001 ms, then 3 ms
      send_event(8'd0, erma_pkg::EV_REL, 32'd1, 20'd1000);
      send_event(8'd0, erma_pkg::EV_ABS, 32'd2, 20'd2000);
      send_event(8'd0, erma_pkg::EV_REL, 32'd2, 20'd5000);
      // other event classes are dropped
      send_event(8'd0, erma_pkg::TYPE_W'(0), 32'hFFFF_FFFF, 20'hFFFFF);
      send_event(8'd0, erma_pkg::TYPE_W'(1), 32'd3, 20'd0);
      send_event(8'd0, erma_pkg::TYPE_W'(4), 32'd2, 20'd6000);
      send_event(8'd255, erma_pkg::TYPE_W'(31), 32'd0, 20'd0);
      // microseconds above one second, gap above 1000 ms
      send_event(8'd255, erma_pkg::EV_ABS, 32'd0, 20'd999);
      send_event(8'd255, erma_pkg::EV_REL, 32'd0, 20'hFFFFF);
      send_event(8'd255, erma_pkg::EV_REL, 32'd1, 20'd49000);
      // seconds at the top of their range
      send_event(8'd1, erma_pkg::EV_ABS, 32'hFFFF_FFFF, 20'd999999);
      send_event(8'd1, erma_pkg::EV_REL, 32'hFFFF_FFFF, 20'hFFFFF);
      send_event(8'd1, erma_pkg::EV_REL, 32'hFFFF_FFFF, 20'hFFFFF);
      send_event(8'd170, erma_pkg::EV_REL, 32'h5555_5555, 20'hAAAAA);
      send_event(8'd85, erma_pkg::EV_ABS, 32'hAAAA_AAAA, 20'h55555);

      for (int n = 0; n < 480; n++) begin
         if (n == 150) begin
            idle_pct = 0;
            stall_pct = 0;
         end
         if (n == 300) begin
            idle_pct = 26;
            stall_pct = 26;
         end
         if (n == 250) wait_for_results();
         pick = $urandom_range(99);
         src = erma_pkg::SRC_W'($urandom_range(2, 5));
         if (pick < 70) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 1100);
            send_ms(src, sent_ms[src] + gap);
         end else if (pick < 75) begin
            send_ms(src, sent_ms[src]);
         end else if (pick < 80) begin
            back = $urandom_range(1, 50);
            send_ms(src, (sent_ms[src] > back) ? sent_ms[src] - back : 0);
         end else if (pick < 90) begin
            kind = erma_pkg::TYPE_W'($urandom_range(31));
            if (kind == erma_pkg::EV_REL || kind == erma_pkg::EV_ABS)
               kind = kind + erma_pkg::TYPE_W'(2);
            send_event(erma_pkg::SRC_W'($urandom_range(255)), kind, $urandom,
                       erma_pkg::USEC_W'($urandom_range((1 << erma_pkg::USEC_W) - 1)));
         end else begin
            kind = $urandom_range(1) ? erma_pkg::EV_REL : erma_pkg::EV_ABS;
            send_event(erma_pkg::SRC_W'($urandom_range(255)), kind, $urandom,
                       erma_pkg::USEC_W'($urandom_range((1 << erma_pkg::USEC_W) - 1)));
         end
      end

      wait_for_results();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #(10_000_000);
      $display("TIMEOUT: results still outstanding");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[files.f]
rtl/erma_pkg.sv
rtl/erma_div.sv
rtl/event_rate_moving_average.sv
tb/event_rate_checker.sv
tb/tb_event_rate_moving_average.sv
